### hw/rtl/fcu_pkg.sv
`default_nettype none

package fcu_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int OUT_W        = 36;
	localparam int COEF_W       = 18;
	localparam int FRAC_BITS    = 15;
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	// 64 products plus rounding headroom
	localparam int ACC_W        = PROD_W + 7;
	localparam int ROM_DEPTH    = 64;
	localparam int ROM_AW       = 6;
	localparam int TAPS_DEFAULT = 61;

	// Q3.15 symmetric high-pass taps, zero past the defined set
	localparam int COEF_ROM [ROM_DEPTH] = '{
		-217, -213, -207, -202, -198, -196, -198, -207, -222, -248,
		-283, -332, -393, -468, -557, -659, -774, -900, -1035, -1177,
		-1322, -1468, -1611, -1749, -1876, -1991, -2089, -2168, -2226, -2263,
		75272,
		-2263, -2226, -2168, -2089, -1991, -1876, -1749, -1611, -1468, -1322,
		-1177, -1035, -900, -774, -659, -557, -468, -393, -332, -283,
		-248, -222, -207, -198, -196, -198, -202, -207, -213, -217,
		0, 0, 0
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    end_of_signal;
	} out_item_t;

	typedef struct packed {
		logic load_in;    // capture accepted sample
		logic load_zero;  // tail push: operand is zero
		logic start;      // rewind tap counter and read pointer
		logic issue;      // step one tap through the MAC
		logic commit;     // load result, write delay line
		logic end_flag;   // final result of the signal
	} fcu_cmd_t;

	typedef struct packed {
		logic last_tap;
		logic out_free;
	} fcu_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FIN
	} fcu_state_t;

	function automatic logic signed [COEF_W-1:0] fcu_coef(input logic [ROM_AW-1:0] idx);
		fcu_coef = COEF_W'(COEF_ROM[idx]);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/fcu_ram.sv
`default_nettype none

module fcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/fcu_datapath.sv
`default_nettype none

module fcu_datapath import fcu_pkg::*; #(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_item_t    in_item,
	input  wire fcu_cmd_t    cmd,
	output fcu_status_t      status,
	output out_item_t        out_item,
	output logic             out_valid,
	input  wire logic        out_ready
);

	localparam int D  = TAPS - 1;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int KW = $clog2(TAPS);

	logic signed [SAMPLE_W-1:0] x_q;
	logic [KW-1:0]              tap_q;
	logic [AW-1:0]              ra_q;
	logic [AW-1:0]              head_q;
	logic [AW-1:0]              head_nxt;
	logic [KW-1:0]              fill_q;
	logic [SAMPLE_W-1:0]        rdata;

	logic                       v_s1, first_s1, zero_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic signed [SAMPLE_W-1:0] opnd;
	logic                       v_s2, first_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    rsum;

	out_item_t                  out_q;
	logic                       out_valid_q;

	assign head_nxt = (head_q == AW'(D - 1)) ? '0 : head_q + 1'b1;

	fcu_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (D)
	) u_dline (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (head_nxt),
		.wdata (x_q),
		.raddr (ra_q),
		.rdata (rdata)
	);

	// tap sequencing and delay-line pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= '0;
			ra_q   <= '0;
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.start) begin
				tap_q <= '0;
				ra_q  <= head_q;
			end else if (cmd.issue) begin
				tap_q <= tap_q + 1'b1;
				if (tap_q != '0) begin
					ra_q <= (ra_q == '0) ? AW'(D - 1) : ra_q - 1'b1;
				end
			end
			if (cmd.commit) begin
				head_q <= head_nxt;
				if (fill_q != KW'(D)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= in_item.sample;
		end else if (cmd.load_zero) begin
			x_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// taps older than the fill count were never written: read as zero
	always_ff @(posedge clk) begin
		first_s1 <= (tap_q == '0);
		zero_s1  <= (tap_q != '0) && (tap_q > fill_q);
		coef_s1  <= fcu_coef(ROM_AW'(tap_q));
	end

	assign opnd = first_s1 ? x_q : (zero_s1 ? '0 : $signed(rdata));

	always_ff @(posedge clk) begin
		prod_s2  <= opnd * coef_s1;
		first_s2 <= first_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	assign rsum = acc_q + ACC_W'(1 << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.filtered      <= rsum[FRAC_BITS +: OUT_W];
			out_q.end_of_signal <= cmd.end_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_item        = out_q;
	assign out_valid       = out_valid_q;
	assign status.last_tap = (tap_q == KW'(TAPS - 1));
	assign status.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### hw/rtl/fcu_ctrl.sv
`default_nettype none

module fcu_ctrl import fcu_pkg::*; #(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_last,
	output logic             in_ready,
	input  wire fcu_status_t status,
	output fcu_cmd_t         cmd
);

	localparam int KW = $clog2(TAPS);

	fcu_state_t    state_q, state_nxt;
	logic          last_q;
	logic [KW-1:0] tail_q;
	logic          accept;
	logic          more_tail;

	assign accept    = in_valid && in_ready;
	assign more_tail = last_q && (tail_q != KW'(TAPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
			tail_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q <= in_last;
				tail_q <= '0;
			end else if (cmd.commit && more_tail) begin
				tail_q <= tail_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.end_flag = last_q && !more_tail;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.start   = 1'b1;
					state_nxt   = ST_RUN;
				end
			end
			ST_PREP: begin
				cmd.load_zero = 1'b1;
				cmd.start     = 1'b1;
				state_nxt     = ST_RUN;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (status.last_tap) begin
					state_nxt = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_nxt = ST_DRAIN2;
			ST_DRAIN2: state_nxt = ST_FIN;
			ST_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = more_tail ? ST_PREP : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/fir_full_convolution_unit.sv
// Full linear convolution with a fixed symmetric FIR held in a coefficient ROM.
// Each sample steps through the single shared MAC, one tap per cycle; no new
// sample is taken until its result, and after a last sample each tail result, is
// committed. A last sample adds TAPS-1 tail results. Reset (arst_n, async, active
// low) empties the delay line by a fill count; no clearing pass is needed. Tail
// pushes leave the delay line all zero.
`default_nettype none

module fir_full_convolution_unit import fcu_pkg::*; #(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	// sample item channel
	input  wire logic      sample_valid,
	output logic           sample_ready,
	input  wire in_item_t  sample_item,
	// result item channel
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_item_t      result_item
);

	// Controller walks IDLE -> RUN (one tap a cycle) -> DRAIN1 and DRAIN2 for the
	// read/multiply/accumulate pipe -> FIN, where the rounded sum is loaded into
	// the output register and the sample is written over the oldest delay entry.
	// A last sample loops through PREP with a zero operand for the tail.
	fcu_cmd_t    cmd;
	fcu_status_t status;

	fcu_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_valid),
		.in_last  (sample_item.is_last),
		.in_ready (sample_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: circular delay line in RAM, ROM coefficient, 32x18 multiplier,
	// exact accumulator, round-half-up by 15 bits, output register.
	fcu_datapath #(
		.TAPS (TAPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (sample_item),
		.cmd       (cmd),
		.status    (status),
		.out_item  (result_item),
		.out_valid (result_valid),
		.out_ready (result_ready)
	);

endmodule

`default_nettype wire

### hw/rtl/fcu_checker.sv
`default_nettype none

module fcu_checker import fcu_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      sample_valid,
	input wire logic      sample_ready,
	input wire in_item_t  sample_item,
	input wire logic      result_valid,
	input wire logic      result_ready,
	input wire out_item_t result_item
);

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while previous item in work");

	// a result never appears right after a sample is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !$rose(result_valid))
		else $error("result appeared too early");

	// two end-of-signal results never come back to back
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result_item.end_of_signal
		|=> !result_valid || !result_item.end_of_signal)
		else $error("two end-of-signal results in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("stalled result changed");

endmodule

bind fir_full_convolution_unit fcu_checker u_fcu_checker (.*);

`default_nettype wire
